// ===== rtl/sat_pkg.sv =====
// Shared types and constants for the software alarm table.
// No dependencies; imported by software_alarm_table and sat_entry_unit.
package sat_pkg;

	// Default table depth
	localparam int NUM_ALARMS_DEF = 8;

	// Alarm word layout: delay in the low bits, periodic flag at the top
	localparam int DELAY_W      = 24;
	localparam int PERIODIC_POS = 31;

	// Command codes
	localparam logic CMD_PROGRAM = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Result kinds
	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_FIRED = 1'b1;

	// One input transfer
	typedef struct packed {
		logic        cmd;
		logic [7:0]  event_id;
		logic [31:0] aux_word;
		logic [31:0] alarm_word;
	} item_t;

	// One result transfer
	typedef struct packed {
		logic        kind;
		logic [7:0]  fired_event;
		logic [31:0] fired_aux;
		logic        table_full;
		logic        last;
	} result_t;

	// One table entry as stored in RAM
	typedef struct packed {
		logic               periodic;
		logic [DELAY_W-1:0] reload;
		logic [DELAY_W-1:0] count;
		logic [7:0]         event_id;
		logic [31:0]        aux_word;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Status from the entry unit to the sequencer
	typedef struct packed {
		logic match;
		logic free;
		logic fire;
	} unit_stat_t;

endpackage

// ===== rtl/software_alarm_table.sv =====
// Top level of the software alarm table: sequencer, active flags, result logic.
// Depends on sat_pkg, sat_ram and sat_entry_unit.
//
// An item is taken when start is high and busy is low; busy then stays high
// through the scan and the finish state; the sequencer reads one entry per
// cycle from the table RAM and runs it through the shared compare/decrement
// unit. A program item returns one acknowledgement; a tick returns one result
// per fired alarm, in entry order, each held back until the next fire or the
// end of the scan, the final one marked last. Each result is shown on result
// with strobe high for a single cycle and cannot be stalled by the receiver.
module software_alarm_table #(
	parameter int NUM_ALARMS = sat_pkg::NUM_ALARMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sat_pkg::item_t   item,
	output logic             strobe,
	output sat_pkg::result_t result
);
	import sat_pkg::*;

	localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ALARMS - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                  state_q;
	item_t                   item_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    issued_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [NUM_ALARMS-1:0]   active_q;
	logic                    match_found_q;
	logic [IDX_W-1:0]        match_idx_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic                    pend_valid_q;
	logic [7:0]              pend_event_q;
	logic [31:0]             pend_aux_q;
	logic                    strobe_q;
	result_t                 result_q;

	logic                    accept;
	logic                    rd_en;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	entry_t                  wr_data;
	entry_t                  rd_data;
	entry_t                  upd;
	unit_stat_t              stat;
	logic                    cur_active;
	logic                    is_tick;
	logic                    word_zero;
	logic                    prog_write;
	entry_t                  new_ent;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign is_tick    = (item_q.cmd == CMD_TICK);
	assign word_zero  = (item_q.alarm_word == '0);
	assign cur_active = active_q[idx_s1];
	assign rd_en      = (state_q == ST_SCAN) && !issued_q;
	assign prog_write = (state_q == ST_FINISH) && !is_tick && !word_zero
		&& (match_found_q || free_found_q);

	// Entry built from a program item
	always_comb begin
		new_ent.periodic = item_q.alarm_word[PERIODIC_POS];
		new_ent.reload   = item_q.alarm_word[DELAY_W-1:0];
		new_ent.count    = item_q.alarm_word[DELAY_W-1:0];
		new_ent.event_id = item_q.event_id;
		new_ent.aux_word = item_q.aux_word;
	end

	// RAM write select: tick write-back during the scan, or program at the end
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = upd;
		if (state_q == ST_SCAN && vld_s1 && is_tick && cur_active) begin
			wr_en = 1'b1;
		end else if (prog_write) begin
			wr_en   = 1'b1;
			wr_addr = match_found_q ? match_idx_q : free_idx_q;
			wr_data = new_ent;
		end
	end

	sat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_ALARMS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(cnt_q),
		.rdata(rd_data)
	);

	sat_entry_unit u_unit (
		.active   (cur_active),
		.ent      (rd_data),
		.key_event(item_q.event_id),
		.key_aux  (item_q.aux_word),
		.stat     (stat),
		.upd      (upd)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			issued_q      <= 1'b0;
			vld_s1        <= 1'b0;
			active_q      <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			vld_s1   <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q       <= ST_SCAN;
						cnt_q         <= '0;
						issued_q      <= 1'b0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						pend_valid_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					// read issue
					if (!issued_q) begin
						if (cnt_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
					// entry processing
					if (vld_s1) begin
						if (is_tick) begin
							if (stat.fire) begin
								if (!rd_data.periodic) begin
									active_q[idx_s1] <= 1'b0;
								end
								if (pend_valid_q) begin
									strobe_q <= 1'b1;
								end
								pend_valid_q <= 1'b1;
							end
						end else begin
							if (stat.match && !match_found_q) begin
								match_found_q <= 1'b1;
							end
							if (stat.free && !free_found_q) begin
								free_found_q <= 1'b1;
							end
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (is_tick) begin
						strobe_q     <= pend_valid_q;
						pend_valid_q <= 1'b0;
					end else begin
						strobe_q <= 1'b1;
						if (word_zero) begin
							if (match_found_q) begin
								active_q[match_idx_q] <= 1'b0;
							end
						end else if (match_found_q) begin
							active_q[match_idx_q] <= 1'b1;
						end else if (free_found_q) begin
							active_q[free_idx_q] <= 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		idx_s1 <= cnt_q;
		if (state_q == ST_SCAN && vld_s1) begin
			if (is_tick) begin
				if (stat.fire) begin
					// hand the held result out, keep the new one back
					result_q.kind        <= KIND_FIRED;
					result_q.fired_event <= pend_event_q;
					result_q.fired_aux   <= pend_aux_q;
					result_q.table_full  <= 1'b0;
					result_q.last        <= 1'b0;
					pend_event_q         <= rd_data.event_id;
					pend_aux_q           <= rd_data.aux_word;
				end
			end else begin
				if (stat.match && !match_found_q) begin
					match_idx_q <= idx_s1;
				end
				if (stat.free && !free_found_q) begin
					free_idx_q <= idx_s1;
				end
			end
		end
		if (state_q == ST_FINISH) begin
			if (is_tick) begin
				result_q.kind        <= KIND_FIRED;
				result_q.fired_event <= pend_event_q;
				result_q.fired_aux   <= pend_aux_q;
				result_q.table_full  <= 1'b0;
			end else begin
				result_q.kind        <= KIND_ACK;
				result_q.fired_event <= item_q.event_id;
				result_q.fired_aux   <= item_q.aux_word;
				result_q.table_full  <= !word_zero && !match_found_q && !free_found_q;
			end
			result_q.last <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== rtl/sat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sat_entry_unit.sv =====
// Shared entry unit: key compare and count decrement for one table entry.
// Depends on sat_pkg.
module sat_entry_unit (
	input  logic                active,
	input  sat_pkg::entry_t     ent,
	input  logic [7:0]          key_event,
	input  logic [31:0]         key_aux,
	output sat_pkg::unit_stat_t stat,
	output sat_pkg::entry_t     upd
);
	import sat_pkg::*;

	logic [DELAY_W-1:0] dec;

	// Saturating decrement; zero after it means the alarm fires
	always_comb begin
		dec = (ent.count != '0) ? ent.count - DELAY_W'(1) : '0;
		stat.match = active && (ent.event_id == key_event) && (ent.aux_word == key_aux);
		stat.free  = !active;
		stat.fire  = active && (dec == '0);
		upd        = ent;
		upd.count  = (dec == '0 && ent.periodic) ? ent.reload : dec;
	end

endmodule
